FILE: hw/rtl/ats_pkg.sv
// Shared types and constants for the alarm and timer scheduler.
// Self-contained; used by ats_cmp_unit and alarm_and_timer_scheduler.

package ats_pkg;

  localparam int unsigned MAX_ALARMS_DEF = 8;
  localparam int unsigned MAX_TIMERS_DEF = 4;

  localparam logic [6:0] ALL_DAYS    = 7'h7F;
  localparam logic [4:0] LAST_HOUR   = 5'd23;
  localparam logic [5:0] LAST_MINUTE = 6'd59;

  typedef enum logic [1:0] {
    FUNC_ADD_ALARM    = 2'd0,
    FUNC_START_TIMER  = 2'd1,
    FUNC_CANCEL_TIMER = 2'd2,
    FUNC_POLL         = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ALARM = 2'd1,
    EV_TIMER = 2'd2
  } event_kind_e;

  typedef enum logic {
    CMP_EQ = 1'b0,
    CMP_GE = 1'b1
  } cmp_op_e;

  typedef struct packed {
    func_e       func;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [6:0]  day_select;
    logic [2:0]  weekday;
    logic [15:0] duration_seconds;
    logic [3:0]  slot_number;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    event_kind_e event_kind;
    logic [2:0]  event_index;
  } out_item_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] days;
  } alarm_t;

  // Request to the shared compare unit.
  typedef struct packed {
    logic        en;
    cmp_op_e     op;
    logic [31:0] lhs;
    logic [31:0] rhs;
  } cmp_req_t;

endpackage

FILE: hw/rtl/ats_cmp_unit.sv
// Shared compare unit: equality for alarm time match, unsigned >= for timer expiry.
// Depends on ats_pkg.

module ats_cmp_unit (
  input  ats_pkg::cmp_req_t req_i,
  output logic              hit_o
);

  always_comb begin
    unique case (req_i.op)
      ats_pkg::CMP_EQ: hit_o = req_i.en && (req_i.lhs == req_i.rhs);
      ats_pkg::CMP_GE: hit_o = req_i.en && (req_i.lhs >= req_i.rhs);
    endcase
  end

endmodule

FILE: hw/rtl/alarm_and_timer_scheduler.sv
// Alarm and timer scheduler: weekly alarm table plus one-shot countdown timers.
// Add, start and cancel go from the exec state to the finish state; a poll scans the alarms
// below the fill count, then the timers, one entry per cycle through the shared compare unit,
// and stops at the first hit. One item at a time: ready returns as the result is loaded, so no
// new item is taken while one is in flight, nor while an older result still waits downstream.
// Reset clears the alarm count, fired marks, timer armed flags and both handshakes.

module alarm_and_timer_scheduler #(
  parameter int unsigned MAX_ALARMS = ats_pkg::MAX_ALARMS_DEF,
  parameter int unsigned MAX_TIMERS = ats_pkg::MAX_TIMERS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ats_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ats_pkg::out_item_t out_item_o
);

  // Index widths for the two stores, count widths and the shared scan counter.
  localparam int unsigned AW  = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int unsigned TW  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned FW  = $clog2(MAX_ALARMS + 1);
  localparam int unsigned TCW = $clog2(MAX_TIMERS + 1);
  localparam int unsigned CW  = (FW > TCW) ? FW : TCW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ALARM,
    ST_TIMER,
    ST_FINISH
  } state_e;

  state_e                state_q, state_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [MAX_ALARMS-1:0] fired_q, fired_d;
  logic [MAX_TIMERS-1:0] active_q, active_d;
  logic [CW-1:0]         scan_q, scan_d;
  ats_pkg::out_item_t    res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  ats_pkg::out_item_t    out_item_q, out_item_d;

  // Payload storage, no reset: entries are only read below the fill count or when armed.
  ats_pkg::in_item_t     item_q;
  ats_pkg::alarm_t       alarm_q [MAX_ALARMS];
  logic [31:0]           deadline_q [MAX_TIMERS];

  logic                  in_fire;
  logic [AW-1:0]         aidx;
  logic [TW-1:0]         tidx;
  logic [TW-1:0]         slot_idx;
  logic [AW-1:0]         fill_idx;
  logic                  add_ok, start_ok, cancel_ok, midnight;
  logic                  free_found;
  logic [TW-1:0]         free_idx;
  logic                  alarm_last, timer_last;
  logic [7:0]            day_bits;
  ats_pkg::cmp_req_t     cmp_req;
  logic                  cmp_hit;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign aidx     = scan_q[AW-1:0];
  assign tidx     = scan_q[TW-1:0];
  assign slot_idx = item_q.slot_number[TW-1:0];
  assign fill_idx = fill_q[AW-1:0];

  // Operation checks on the held item.
  assign add_ok    = (fill_q < FW'(MAX_ALARMS))
                  && (item_q.hour_of_day <= ats_pkg::LAST_HOUR)
                  && (item_q.minute_of_hour <= ats_pkg::LAST_MINUTE);
  assign start_ok  = (item_q.duration_seconds != 16'd0) && free_found;
  assign cancel_ok = ({1'b0, item_q.slot_number} < 5'(MAX_TIMERS));
  assign midnight  = (item_q.hour_of_day == 5'd0) && (item_q.minute_of_hour == 6'd0);

  assign alarm_last = (CW'(scan_q + CW'(1)) == CW'(fill_q));
  assign timer_last = (scan_q == CW'(MAX_TIMERS - 1));

  // Lowest unarmed timer slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (!active_q[i] && !free_found) begin
        free_found = 1'b1;
        free_idx   = TW'(i);
      end
    end
  end

  // Feed the shared compare unit: alarm time match during the alarm scan,
  // deadline expiry during the timer scan. Weekday 7 lands on the padding zero.
  assign day_bits = {1'b0, alarm_q[aidx].days};

  always_comb begin
    cmp_req = '0;
    unique case (state_q)
      ST_ALARM: begin
        cmp_req.en  = !fired_q[aidx] && day_bits[item_q.weekday];
        cmp_req.op  = ats_pkg::CMP_EQ;
        cmp_req.lhs = 32'({item_q.hour_of_day, item_q.minute_of_hour});
        cmp_req.rhs = 32'({alarm_q[aidx].hour, alarm_q[aidx].minute});
      end
      ST_TIMER: begin
        cmp_req.en  = active_q[tidx];
        cmp_req.op  = ats_pkg::CMP_GE;
        cmp_req.lhs = item_q.now_seconds;
        cmp_req.rhs = deadline_q[tidx];
      end
      default: cmp_req = '0;
    endcase
  end

  ats_cmp_unit u_cmp (
    .req_i (cmp_req),
    .hit_o (cmp_hit)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    fired_d     = fired_q;
    active_d    = active_q;
    scan_d      = scan_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;

    // Drop the output item once it is taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d   = '0;
        state_d = ST_FINISH;
        unique case (item_q.func)
          ats_pkg::FUNC_ADD_ALARM: begin
            res_d.accepted = add_ok;
            if (add_ok) begin
              fired_d[fill_idx] = 1'b0;
              fill_d            = FW'(fill_q + FW'(1));
            end
          end
          ats_pkg::FUNC_START_TIMER: begin
            res_d.accepted = start_ok;
            if (start_ok) begin
              active_d[free_idx] = 1'b1;
            end
          end
          ats_pkg::FUNC_CANCEL_TIMER: begin
            res_d.accepted = cancel_ok;
            if (cancel_ok) begin
              active_d[slot_idx] = 1'b0;
            end
          end
          ats_pkg::FUNC_POLL: begin
            // Clear fired marks at midnight, then scan alarms (if any) and timers.
            if (midnight) begin
              fired_d = '0;
            end
            scan_d  = '0;
            state_d = (fill_q == '0) ? ST_TIMER : ST_ALARM;
          end
        endcase
      end
      ST_ALARM: begin
        if (cmp_hit) begin
          fired_d[aidx]     = 1'b1;
          res_d.event_kind  = ats_pkg::EV_ALARM;
          res_d.event_index = 3'(scan_q);
          state_d           = ST_FINISH;
        end else if (alarm_last) begin
          scan_d  = '0;
          state_d = ST_TIMER;
        end else begin
          scan_d = CW'(scan_q + CW'(1));
        end
      end
      ST_TIMER: begin
        if (cmp_hit) begin
          active_d[tidx]    = 1'b0;
          res_d.event_kind  = ats_pkg::EV_TIMER;
          res_d.event_index = 3'(scan_q);
          state_d           = ST_FINISH;
        end else if (timer_last) begin
          state_d = ST_FINISH;
        end else begin
          scan_d = CW'(scan_q + CW'(1));
        end
      end
      ST_FINISH: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_item_d  = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      fired_q     <= '0;
      active_q    <= '0;
      scan_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      fired_q     <= fired_d;
      active_q    <= active_d;
      scan_q      <= scan_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  // Item capture and table writes.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    if (state_q == ST_EXEC) begin
      if ((item_q.func == ats_pkg::FUNC_ADD_ALARM) && add_ok) begin
        alarm_q[fill_idx].hour   <= item_q.hour_of_day;
        alarm_q[fill_idx].minute <= item_q.minute_of_hour;
        alarm_q[fill_idx].days   <= (item_q.day_select == 7'd0) ? ats_pkg::ALL_DAYS
                                                                : item_q.day_select;
      end
      if ((item_q.func == ats_pkg::FUNC_START_TIMER) && start_ok) begin
        deadline_q[free_idx] <= item_q.now_seconds + 32'(item_q.duration_seconds);
      end
      if ((item_q.func == ats_pkg::FUNC_CANCEL_TIMER) && cancel_ok) begin
        deadline_q[slot_idx] <= '0;
      end
    end
  end

  // Assertions.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_ALARMS))
    else $error("alarm fill count beyond table size");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("output item loaded outside finish state");

  a_accept_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_item_q.accepted && (out_item_q.event_kind != ats_pkg::EV_NONE)))
    else $error("result both accepted and reporting an event");

  a_alarm_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALARM && cmp_hit) |=> fired_q[$past(aidx)])
    else $error("fired alarm not marked");

  a_timer_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TIMER && cmp_hit) |=> !active_q[$past(tidx)])
    else $error("expired timer still armed");

endmodule

FILE: tb/sv/ats_checker.sv
// Checker for the alarm and timer scheduler: watches both item channels, predicts each result
// and compares it field by field. Depends on ats_pkg only.

module ats_checker
  import ats_pkg::*;
#(
  parameter int unsigned MAX_ALARMS = MAX_ALARMS_DEF,
  parameter int unsigned MAX_TIMERS = MAX_TIMERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_cnt_o,
  output int        pending_cnt_o,
  output int        alarm_cnt_o,
  output int        timer_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  alarm_t      alarm_tab   [MAX_ALARMS];
  logic        fired_mark  [MAX_ALARMS];
  int          alarm_fill;
  logic        timer_armed [MAX_TIMERS];
  logic [31:0] timer_due   [MAX_TIMERS];
  out_item_t   pending_outcomes [$];

  // Apply one item to the shadow state and return the result it must produce.
  function automatic out_item_t schedule_outcome(in_item_t it);
    out_item_t  res;
    logic       hit;
    logic [7:0] day_bits;
    int         i;
    res = '{accepted: 1'b0, event_kind: EV_NONE, event_index: 3'd0};
    hit = 1'b0;
    case (it.func)
      FUNC_ADD_ALARM: begin
        if (alarm_fill < int'(MAX_ALARMS) && it.hour_of_day <= LAST_HOUR &&
            it.minute_of_hour <= LAST_MINUTE) begin
          alarm_tab[alarm_fill].hour   = it.hour_of_day;
          alarm_tab[alarm_fill].minute = it.minute_of_hour;
          alarm_tab[alarm_fill].days   = (it.day_select == '0) ? ALL_DAYS : it.day_select;
          fired_mark[alarm_fill]       = 1'b0;
          alarm_fill++;
          res.accepted = 1'b1;
        end
      end
      FUNC_START_TIMER: begin
        if (it.duration_seconds != '0) begin
          for (i = 0; i < int'(MAX_TIMERS); i++) begin
            if (!hit && !timer_armed[i]) begin
              timer_armed[i] = 1'b1;
              timer_due[i]   = it.now_seconds + 32'(it.duration_seconds);
              hit            = 1'b1;
              res.accepted   = 1'b1;
            end
          end
        end
      end
      FUNC_CANCEL_TIMER: begin
        if (it.slot_number < MAX_TIMERS) begin
          timer_armed[it.slot_number] = 1'b0;
          timer_due[it.slot_number]   = '0;
          res.accepted                = 1'b1;
        end
      end
      FUNC_POLL: begin
        if (it.hour_of_day == '0 && it.minute_of_hour == '0) begin
          for (i = 0; i < alarm_fill; i++) fired_mark[i] = 1'b0;
        end
        for (i = 0; i < alarm_fill; i++) begin
          // weekday 7 lands on the padding bit and matches nothing
          day_bits = {1'b0, alarm_tab[i].days};
          if (!hit && !fired_mark[i] && day_bits[it.weekday] &&
              alarm_tab[i].hour == it.hour_of_day &&
              alarm_tab[i].minute == it.minute_of_hour) begin
            fired_mark[i]   = 1'b1;
            res.event_kind  = EV_ALARM;
            res.event_index = 3'(i);
            hit             = 1'b1;
          end
        end
        for (i = 0; i < int'(MAX_TIMERS); i++) begin
          if (!hit && timer_armed[i] && it.now_seconds >= timer_due[i]) begin
            timer_armed[i]  = 1'b0;
            res.event_kind  = EV_TIMER;
            res.event_index = 3'(i);
            hit             = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic flag_mismatch(string field, int unsigned want_v, int unsigned got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_ALARMS); i++) begin
        alarm_tab[i]  = '0;
        fired_mark[i] = 1'b0;
      end
      for (int i = 0; i < int'(MAX_TIMERS); i++) begin
        timer_armed[i] = 1'b0;
        timer_due[i]   = '0;
      end
      alarm_fill = 0;
      pending_outcomes.delete();
      pending_cnt_o = 0;
      fail_cnt_o    = 0;
      alarm_cnt_o   = 0;
      timer_cnt_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) pending_outcomes.push_back(schedule_outcome(in_item_i));
      if (out_valid_i && out_ready_i) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with nothing expected, actual acc=%0d kind=%0d idx=%0d",
                   $time, out_item_i.accepted, out_item_i.event_kind, out_item_i.event_index);
          fail_cnt_o++;
        end else begin
          want = pending_outcomes.pop_front();
          if (out_item_i.accepted !== want.accepted)
            flag_mismatch("accepted", want.accepted, out_item_i.accepted);
          if (out_item_i.event_kind !== want.event_kind)
            flag_mismatch("event_kind", want.event_kind, out_item_i.event_kind);
          if (out_item_i.event_index !== want.event_index)
            flag_mismatch("event_index", want.event_index, out_item_i.event_index);
          if (want.event_kind == EV_ALARM) alarm_cnt_o++;
          if (want.event_kind == EV_TIMER) timer_cnt_o++;
        end
      end
      pending_cnt_o = pending_outcomes.size();
    end
  end

endmodule

FILE: tb/sv/tb_alarm_and_timer_scheduler.sv
// Testbench top for the alarm and timer scheduler: clock, reset, stimulus and verdict.
// Depends on ats_pkg, alarm_and_timer_scheduler and ats_checker.

module tb_alarm_and_timer_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import ats_pkg::*;

  localparam int RANDOM_ITEMS = 1420;
  // Timeout bound, set well above the worst case for about 1450 items.
  localparam int CYCLE_LIMIT  = 600000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_item;

  int fail_cnt;
  int pending_cnt;
  int alarm_cnt;
  int timer_cnt;
  int cycle_cnt  = 0;
  int sent_cnt   = 0;
  int stall_left = 0;
  bit idle_en    = 1'b1;

  // Alarms the table should hold; polls aim at these to reach the firing paths.
  logic [4:0] alarm_hh [MAX_ALARMS_DEF];
  logic [5:0] alarm_mm [MAX_ALARMS_DEF];
  logic [6:0] alarm_dd [MAX_ALARMS_DEF];
  int         alarm_known = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  alarm_and_timer_scheduler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  ats_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_cnt_o   (fail_cnt),
    .pending_cnt_o(pending_cnt),
    .alarm_cnt_o  (alarm_cnt),
    .timer_cnt_o  (timer_cnt)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_cnt, pending_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver side: drop ready for random stretches while idling is on.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready = 1'b0;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (idle_en && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // Fill every field at random so that unused fields toggle too.
  function automatic in_item_t random_fields(func_e f);
    in_item_t it;
    it.func             = f;
    it.hour_of_day      = 5'($urandom_range(0, 31));
    it.minute_of_hour   = 6'($urandom_range(0, 63));
    it.day_select       = 7'($urandom_range(0, 127));
    it.weekday          = 3'($urandom_range(0, 7));
    it.duration_seconds = 16'($urandom_range(0, 65535));
    it.slot_number      = 4'($urandom_range(0, 15));
    it.now_seconds      = $urandom;
    return it;
  endfunction

  // Present one item from a falling edge and hold it until it is taken.
  task automatic send_item(input in_item_t it);
    int gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (it.func == FUNC_ADD_ALARM && it.hour_of_day <= LAST_HOUR &&
        it.minute_of_hour <= LAST_MINUTE && alarm_known < int'(MAX_ALARMS_DEF)) begin
      alarm_hh[alarm_known] = it.hour_of_day;
      alarm_mm[alarm_known] = it.minute_of_hour;
      alarm_dd[alarm_known] = (it.day_select == '0) ? ALL_DAYS : it.day_select;
      alarm_known++;
    end
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_op(func_e f, logic [4:0] hh, logic [5:0] mm, logic [6:0] dd,
                         logic [2:0] wd, logic [15:0] dur, logic [3:0] slot,
                         logic [31:0] now);
    in_item_t it;
    it = '{func: f, hour_of_day: hh, minute_of_hour: mm, day_select: dd, weekday: wd,
           duration_seconds: dur, slot_number: slot, now_seconds: now};
    send_item(it);
  endtask

  initial begin
    in_item_t    it;
    logic [31:0] epoch;
    int          n;
    int          r;
    int          k;
    int          w;

    // Hold reset, then release it on a falling edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: field extremes, rejections and each corner of the schedule.
    // Reject adds with hour above 23, minute above 59, and both at their top values.
    send_op(FUNC_ADD_ALARM, 5'd24, 6'd0, 7'h01, 3'd0, 16'd0, 4'd0, 32'd0);
    send_op(FUNC_ADD_ALARM, 5'd0, 6'd60, 7'h01, 3'd0, 16'd0, 4'd0, 32'd0);
    send_op(FUNC_ADD_ALARM, 5'd31, 6'd63, 7'h7F, 3'd7, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    // Alarm 0 at 23:59 with an empty mask, so every day.
    send_op(FUNC_ADD_ALARM, 5'd23, 6'd59, 7'h00, 3'd0, 16'd0, 4'd0, 32'd0);
    // Alarm 1 at midnight on day 0 only, alarm 2 at 12:30 on day 6 only.
    send_op(FUNC_ADD_ALARM, 5'd0, 6'd0, 7'h01, 3'd0, 16'd0, 4'd0, 32'd0);
    send_op(FUNC_ADD_ALARM, 5'd12, 6'd30, 7'h40, 3'd0, 16'd0, 4'd0, 32'd0);
    // Fill the table with random well-formed alarms.
    repeat (5) begin
      it = random_fields(FUNC_ADD_ALARM);
      it.hour_of_day    = 5'($urandom_range(0, 23));
      it.minute_of_hour = 6'($urandom_range(0, 59));
      send_item(it);
    end
    // Table full now: reject.
    send_op(FUNC_ADD_ALARM, 5'd8, 6'd0, 7'h7F, 3'd0, 16'd0, 4'd0, 32'd0);
    // Zero duration is rejected; a duration past the top of time wraps the deadline.
    send_op(FUNC_START_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd0, 4'd0, 32'd1000);
    send_op(FUNC_START_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'hFFFF, 4'd0, 32'hFFFF_FFFF);
    send_op(FUNC_START_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd1, 4'd0, 32'd1000);
    send_op(FUNC_START_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd3600, 4'd0, 32'd1000);
    send_op(FUNC_START_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd1, 4'd0, 32'd1000);
    // No free slot left.
    send_op(FUNC_START_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd5, 4'd0, 32'd1000);
    // Cancel out of range (slot 15, then slot 4), then a live slot, then the same slot once inactive.
    send_op(FUNC_CANCEL_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd0, 4'hF, 32'd0);
    send_op(FUNC_CANCEL_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd0, 4'd4, 32'd0);
    send_op(FUNC_CANCEL_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd0, 4'd3, 32'd0);
    send_op(FUNC_CANCEL_TIMER, 5'd0, 6'd0, 7'h00, 3'd0, 16'd0, 4'd3, 32'd0);
    // Fire alarm 0, then the same minute again: no refire, a timer expires instead.
    send_op(FUNC_POLL, 5'd23, 6'd59, 7'h00, 3'd3, 16'd0, 4'd0, 32'd1000);
    send_op(FUNC_POLL, 5'd23, 6'd59, 7'h00, 3'd3, 16'd0, 4'd0, 32'd1001);
    // Midnight on weekday 7 clears the marks but matches no day; the wrapped timer expires.
    send_op(FUNC_POLL, 5'd0, 6'd0, 7'h00, 3'd7, 16'd0, 4'd0, 32'd70000);
    send_op(FUNC_POLL, 5'd0, 6'd0, 7'h00, 3'd0, 16'd0, 4'd0, 32'd70000);
    // Out-of-range time on poll matches nothing.
    send_op(FUNC_POLL, 5'd31, 6'd63, 7'h7F, 3'd6, 16'd0, 4'd0, 32'd0);
    send_op(FUNC_POLL, 5'd12, 6'd30, 7'h00, 3'd6, 16'd0, 4'd0, 32'd4600);

    // Random part: mostly realistic traffic on an advancing clock, plus noise.
    epoch = 32'd5000;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Run every third block of 150 items with no idling on either side.
      idle_en = ((n / 150) % 3) != 2;
      if ($urandom_range(0, 199) == 0) epoch = 32'hFFFF_FE00 + 32'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 45) begin
        it = random_fields(FUNC_POLL);
        k  = $urandom_range(0, 99);
        if (k < 15) begin
          it.hour_of_day    = '0;
          it.minute_of_hour = '0;
        end else if (k < 70 && alarm_known > 0) begin
          k = $urandom_range(0, alarm_known - 1);
          it.hour_of_day    = alarm_hh[k];
          it.minute_of_hour = alarm_mm[k];
          // Aim for a weekday the alarm is set for.
          w = $urandom_range(0, 6);
          repeat (6) if (!alarm_dd[k][w]) w = $urandom_range(0, 6);
          it.weekday = 3'(w);
        end
        if (it.weekday == 3'd7 && $urandom_range(0, 3) != 0) it.weekday = 3'($urandom_range(0, 6));
        if ($urandom_range(0, 9) != 0) begin
          it.now_seconds = epoch;
          epoch          = epoch + 32'($urandom_range(0, 300));
        end
      end else if (r < 70) begin
        it = random_fields(FUNC_START_TIMER);
        k  = $urandom_range(0, 9);
        if (k < 8) it.duration_seconds = 16'($urandom_range(1, 600));
        else if (k == 8) it.duration_seconds = '0;
        if ($urandom_range(0, 9) != 0) it.now_seconds = epoch;
      end else if (r < 85) begin
        it = random_fields(FUNC_CANCEL_TIMER);
        if ($urandom_range(0, 4) != 0) it.slot_number = 4'($urandom_range(0, 3));
      end else begin
        // Table is full by now: these are rejected adds with random content.
        it = random_fields(FUNC_ADD_ALARM);
      end
      send_item(it);
    end
    in_valid = 1'b0;

    // Drain: wait for every result, then run on for longer than the longest poll takes.
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d items in %0d cycles; %0d alarms fired and %0d timers expired.",
             sent_cnt, cycle_cnt, alarm_cnt, timer_cnt);
    $display("Covered adds, timer starts and cancels, midnight clears and wrapped deadlines.");
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ats_pkg.sv
hw/rtl/ats_cmp_unit.sv
hw/rtl/alarm_and_timer_scheduler.sv
tb/sv/ats_checker.sv
tb/sv/tb_alarm_and_timer_scheduler.sv
